### rtl/core/cgs_pkg.sv
// Shared constants, codes and types of the cost grid sampler.
// Used by the channel interfaces, the multiply-accumulate unit and the top level.
`default_nettype none

package cgs_pkg;

  localparam int MAX_COLS  = 256;
  localparam int MAX_ROWS  = 256;
  localparam int FRAC_BITS = 8;

  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int ADDR_W = COL_W + ROW_W;
  localparam int DEPTH  = MAX_COLS * MAX_ROWS;

  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam int COORD_W   = 18;
  localparam int CELL_W    = 8;
  localparam int SAMPLE_W  = 16;
  localparam int GRAD_W    = 11;

  localparam int IDX_W     = COORD_W - FRAC_BITS;
  localparam int POS_W     = IDX_W + 1;
  localparam int WGT_W     = FRAC_BITS + 1;
  localparam int MUL_A_W   = WGT_W + 1;
  localparam int MUL_B_W   = 2 * CELL_W + 1;
  localparam int ACC_W     = 26;
  localparam int OUT_SHIFT = 2 * FRAC_BITS - 8;
  localparam int STEP_W    = 4;

  localparam logic [CELL_W-1:0] OUT_COST = 8'd255;

  localparam logic [1:0] FUNC_WRITE  = 2'd0;
  localparam logic [1:0] FUNC_MERGE  = 2'd1;
  localparam logic [1:0] FUNC_SAMPLE = 2'd2;
  localparam logic [1:0] FUNC_GRAD   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 1'b1;

  typedef struct packed {
    logic en;
    logic clr;
  } mac_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/cgs_if.sv
// Request and response channels of the cost grid sampler (valid/ready).
// Depends on cgs_pkg for field widths.
`default_nettype none

interface cgs_req_if
  import cgs_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [1:0]                func;
  logic [COL_W-1:0]          cell_col;
  logic [ROW_W-1:0]          cell_row;
  logic [CELL_W-1:0]         cell_cost;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;

  modport source (output valid, func, cell_col, cell_row, cell_cost, coord_x, coord_y,
                  input ready);
  modport sink (input valid, func, cell_col, cell_row, cell_cost, coord_x, coord_y,
                output ready);
endinterface

interface cgs_rsp_if
  import cgs_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [SAMPLE_W-1:0]      sample_value;
  logic signed [GRAD_W-1:0] grad_x;
  logic signed [GRAD_W-1:0] grad_y;
  logic                     in_map;

  modport source (output valid, sample_value, grad_x, grad_y, in_map, input ready);
  modport sink (input valid, sample_value, grad_x, grad_y, in_map, output ready);
endinterface

`default_nettype wire

### rtl/core/cgs_mac.sv
// Shared signed multiply-accumulate unit of the cost grid sampler.
// Depends on cgs_pkg for operand widths and the control struct.
`default_nettype none

module cgs_mac
  import cgs_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mac_ctrl_t                 ctrl_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic signed [MUL_B_W-1:0] b_i,
  output logic signed [ACC_W-1:0]   sum_o,
  output logic signed [ACC_W-1:0]   acc_o
);

  logic signed [MUL_A_W+MUL_B_W-1:0] prod;
  logic signed [ACC_W-1:0]           base;
  logic signed [ACC_W-1:0]           acc_q;
  logic                              acc_vld_q;

  assign prod  = a_i * b_i;
  assign base  = (ctrl_i.clr || !acc_vld_q) ? '0 : acc_q;
  assign sum_o = base + $signed(prod[ACC_W-1:0]);
  assign acc_o = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_vld_q <= 1'b0;
    end else if (ctrl_i.en) begin
      acc_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      acc_q <= sum_o;
    end
  end

endmodule

`default_nettype wire

### rtl/core/cost_grid_sampler.sv
// Cost grid sampler: a 256 x 256 grid of 8-bit costs in one single-port memory, with
// cell write, max-merge, bilinear sample and central-difference gradient requests.
// One request is in work at a time; req_i.ready is high only while idle. A write or
// merge reads the cell and then writes it (a merge only if the new cost is larger);
// a sample outside the map reads no cell. The result waits in the output register,
// and the next request is taken while it waits. The work follows from the one memory
// port (one cell read per cycle: 4 for a sample, 8 for a gradient) and from the one
// shared multiply-accumulate unit that weights each cell and, for a sample, then blends the two row sums.
// No clearing pass runs after reset; a cell must be written before it is read.
`default_nettype none

module cost_grid_sampler
  import cgs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  cgs_req_if.sink              req_i,
  cgs_rsp_if.source            rsp_o
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_CELL_RD = 6'b000010,
    S_CELL_WR = 6'b000100,
    S_READ    = 6'b001000,
    S_COMB    = 6'b010000,
    S_DONE    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [CFG_W-1:0] map_w_q, map_h_q;
  logic [CFG_W-1:0] eff_w, eff_h;

  logic [STEP_W-1:0] k_q, k_d, n_steps;
  logic [2:0]        kp_q;
  logic              rd_vld_q, rd_vld_d;
  logic              cmb_q, cmb_d;
  logic              oob_q, oob_now;

  logic [1:0]              func_q;
  logic [CELL_W-1:0]       cost_q;
  logic signed [POS_W-1:0] base_x_q, base_y_q;
  logic [FRAC_BITS-1:0]    fx_q, fy_q;
  logic                    in_map_q;
  logic [MUL_B_W-1:0]      top_q, bot_q;

  logic                      out_valid_q, out_load;
  logic [SAMPLE_W-1:0]       out_sample_q, out_sample_d;
  logic signed [GRAD_W-1:0]  out_gx_q, out_gx_d, out_gy_q, out_gy_d;
  logic                      out_in_map_q, out_in_map_d;

  logic                    accept;
  logic signed [IDX_W-1:0] x_fl, y_fl, x_tr, y_tr;
  logic [FRAC_BITS-1:0]    fx_in, fy_in;
  logic [POS_W-1:0]        x_ceil, y_ceil;
  logic                    in_range;

  logic signed [POS_W-1:0] off_x, off_y, cur_x, cur_y;
  logic [ADDR_W-1:0]       mem_addr;
  logic                    mem_we;
  logic [CELL_W-1:0]       cost_mem_q [DEPTH];
  logic [CELL_W-1:0]       rd_q;
  logic [CELL_W-1:0]       cell_val;

  logic [WGT_W-1:0]          ex, ey;
  logic [1:0]                mag;
  mac_ctrl_t                 mac_ctrl;
  logic signed [MUL_A_W-1:0] mac_a;
  logic signed [MUL_B_W-1:0] mac_b;
  logic signed [ACC_W-1:0]   mac_sum, mac_acc;
  logic [ACC_W-1:0]          rnd;

  // Map size registers; their effective values are saturated to the grid size.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_w_q <= CFG_W'(MAX_COLS);
      map_h_q <= CFG_W'(MAX_ROWS);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAP_WIDTH:  map_w_q <= cfg_data_i;
        CFG_MAP_HEIGHT: map_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign eff_w = (map_w_q > CFG_W'(MAX_COLS)) ? CFG_W'(MAX_COLS) : map_w_q;
  assign eff_h = (map_h_q > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : map_h_q;

  // Request decode.
  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  assign x_fl  = req_i.coord_x[COORD_W-1:FRAC_BITS];
  assign y_fl  = req_i.coord_y[COORD_W-1:FRAC_BITS];
  assign fx_in = req_i.coord_x[FRAC_BITS-1:0];
  assign fy_in = req_i.coord_y[FRAC_BITS-1:0];
  assign x_tr  = x_fl + IDX_W'(req_i.coord_x[COORD_W-1] && (fx_in != '0));
  assign y_tr  = y_fl + IDX_W'(req_i.coord_y[COORD_W-1] && (fy_in != '0));

  assign x_ceil   = {1'b0, x_fl} + POS_W'(fx_in != '0);
  assign y_ceil   = {1'b0, y_fl} + POS_W'(fy_in != '0);
  assign in_range = !req_i.coord_x[COORD_W-1] && !req_i.coord_y[COORD_W-1]
                    && (x_ceil < POS_W'(eff_w)) && (y_ceil < POS_W'(eff_h));

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q   <= req_i.func;
      cost_q   <= req_i.cell_cost;
      fx_q     <= fx_in;
      fy_q     <= fy_in;
      in_map_q <= in_range;
      case (req_i.func)
        FUNC_SAMPLE: begin
          base_x_q <= {x_fl[IDX_W-1], x_fl};
          base_y_q <= {y_fl[IDX_W-1], y_fl};
        end
        FUNC_GRAD: begin
          base_x_q <= {x_tr[IDX_W-1], x_tr};
          base_y_q <= {y_tr[IDX_W-1], y_tr};
        end
        default: begin
          base_x_q <= POS_W'(req_i.cell_col);
          base_y_q <= POS_W'(req_i.cell_row);
        end
      endcase
    end
  end

  // Cell offset of the current read step.
  assign n_steps = (func_q == FUNC_GRAD) ? STEP_W'(8) : STEP_W'(4);

  always_comb begin
    off_x = '0;
    off_y = '0;
    mag   = k_q[1] ? 2'd2 : 2'd1;
    case (func_q)
      FUNC_SAMPLE: begin
        off_x = POS_W'(k_q[0]);
        off_y = POS_W'(k_q[1]);
      end
      FUNC_GRAD: begin
        if (k_q[2]) begin
          off_y = k_q[0] ? -POS_W'(mag) : POS_W'(mag);
        end else begin
          off_x = k_q[0] ? -POS_W'(mag) : POS_W'(mag);
        end
      end
      default: ;
    endcase
  end

  assign cur_x    = base_x_q + off_x;
  assign cur_y    = base_y_q + off_y;
  assign oob_now  = cur_x[POS_W-1] || cur_y[POS_W-1]
                    || (cur_x[IDX_W-1:0] >= IDX_W'(eff_w))
                    || (cur_y[IDX_W-1:0] >= IDX_W'(eff_h));
  assign mem_addr = {cur_y[ROW_W-1:0], cur_x[COL_W-1:0]};
  assign mem_we   = (state_q == S_CELL_WR) && !oob_q
                    && ((func_q == FUNC_WRITE) || (cost_q > rd_q));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cost_mem_q[mem_addr] <= cost_q;
    end
    rd_q  <= cost_mem_q[mem_addr];
    oob_q <= oob_now;
    kp_q  <= k_q[2:0];
  end

  assign cell_val = oob_q ? OUT_COST : rd_q;

  // Operand selection for the shared multiply-accumulate unit.
  assign ex = WGT_W'(1 << FRAC_BITS) - {1'b0, fx_q};
  assign ey = WGT_W'(1 << FRAC_BITS) - {1'b0, fy_q};

  always_comb begin
    mac_ctrl = '0;
    mac_a    = '0;
    mac_b    = '0;
    if (state_q == S_READ && rd_vld_q) begin
      mac_ctrl.en = 1'b1;
      mac_b       = $signed(MUL_B_W'(cell_val));
      if (func_q == FUNC_SAMPLE) begin
        mac_a        = kp_q[0] ? $signed({2'b00, fx_q}) : $signed({1'b0, ex});
        mac_ctrl.clr = !kp_q[0];
      end else begin
        mac_a        = kp_q[0] ? -MUL_A_W'(kp_q[1] ? 1 : 2) : MUL_A_W'(kp_q[1] ? 1 : 2);
        mac_ctrl.clr = (kp_q[1:0] == 2'd0);
      end
    end else if (state_q == S_COMB) begin
      mac_ctrl.en = 1'b1;
      if (!cmb_q) begin
        mac_a        = $signed({1'b0, ey});
        mac_b        = $signed(top_q);
        mac_ctrl.clr = 1'b1;
      end else begin
        mac_a = $signed({2'b00, fy_q});
        mac_b = $signed(bot_q);
      end
    end
  end

  cgs_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .sum_o  (mac_sum),
    .acc_o  (mac_acc)
  );

  // Hold row sums of a sample, or the x gradient.
  always_ff @(posedge clk_i) begin
    if (state_q == S_READ && rd_vld_q && kp_q[1:0] == 2'd1 && func_q == FUNC_SAMPLE) begin
      top_q <= mac_sum[MUL_B_W-1:0];
    end
    if (state_q == S_READ && rd_vld_q && kp_q == 3'd3) begin
      if (func_q == FUNC_SAMPLE) begin
        bot_q <= mac_sum[MUL_B_W-1:0];
      end else begin
        top_q <= mac_sum[MUL_B_W-1:0];
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    cmb_d    = cmb_q;
    rd_vld_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        k_d   = '0;
        cmb_d = 1'b0;
        if (accept) begin
          case (req_i.func)
            FUNC_WRITE, FUNC_MERGE: state_d = S_CELL_RD;
            FUNC_SAMPLE:            state_d = in_range ? S_READ : S_DONE;
            default:                state_d = S_READ;
          endcase
        end
      end
      S_CELL_RD: state_d = S_CELL_WR;
      S_CELL_WR: state_d = S_DONE;
      S_READ: begin
        if (k_q != n_steps) begin
          k_d      = k_q + STEP_W'(1);
          rd_vld_d = 1'b1;
        end else begin
          state_d = (func_q == FUNC_SAMPLE) ? S_COMB : S_DONE;
        end
      end
      S_COMB: begin
        cmb_d = 1'b1;
        if (cmb_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      k_q      <= '0;
      cmb_q    <= 1'b0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      k_q      <= k_d;
      cmb_q    <= cmb_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  // Result formatting and output register.
  assign rnd      = mac_acc + ACC_W'(1 << (OUT_SHIFT - 1));
  assign out_load = (state_q == S_DONE) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    out_sample_d = '0;
    out_gx_d     = '0;
    out_gy_d     = '0;
    out_in_map_d = 1'b0;
    case (func_q)
      FUNC_SAMPLE: begin
        out_sample_d = in_map_q ? rnd[OUT_SHIFT +: SAMPLE_W] : {OUT_COST, 8'd0};
        out_in_map_d = in_map_q;
      end
      FUNC_GRAD: begin
        out_gx_d     = $signed(top_q[GRAD_W-1:0]);
        out_gy_d     = mac_acc[GRAD_W-1:0];
        out_in_map_d = in_map_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_load || (out_valid_q && !rsp_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sample_q <= out_sample_d;
      out_gx_q     <= out_gx_d;
      out_gy_q     <= out_gy_d;
      out_in_map_q <= out_in_map_d;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.sample_value = out_sample_q;
  assign rsp_o.grad_x       = out_gx_q;
  assign rsp_o.grad_y       = out_gy_q;
  assign rsp_o.in_map       = out_in_map_q;

endmodule

`default_nettype wire
